// File: hdl/slp_pkg.sv
// Shared types and constants of the server address list parser.
package slp_pkg;

    // Parser phase within one datagram.
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PREFIX,
        PH_BODY,
        PH_DISCARD
    } t_phase;

    // Result kind codes.
    typedef enum logic [2:0] {
        KIND_RECORD    = 3'd0,
        KIND_CLEAN     = 3'd1,
        KIND_ZERO_PORT = 3'd2,
        KIND_ILLEGAL   = 3'd3,
        KIND_TRUNC     = 3'd4,
        KIND_SHORT     = 3'd5
    } t_kind;

    // Record prefix bytes.
    localparam logic [7:0] MARK_V4 = 8'h5C;
    localparam logic [7:0] MARK_V6 = 8'h2F;

    // Address lengths in bytes.
    localparam logic [4:0] V4_BYTES = 5'd4;
    localparam logic [4:0] V6_BYTES = 5'd16;

    // One input request.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // One result request.
    typedef struct packed {
        t_kind       kind;
        logic        is_ipv6;
        logic [63:0] addr_upper;
        logic [63:0] addr_lower;
        logic [15:0] port_number;
        logic        end_of_message;
    } t_result;

endpackage

// File: hdl/server_address_list_parser.sv
// Top level of the server address list parser.
//
//   Channel  | Direction | Payload
//   ---------+-----------+---------------------------------------------------
//   s_axis   | in        | tdata: data_byte; tlast: last_byte
//   m_axis   | out       | tdata: addr_upper, addr_lower, port_number;
//            |           | tuser: kind, is_ipv6; tlast: end_of_message
//
// One byte is taken every cycle while no result stalls; a byte and its result are
// held in the input register and then the result register, around the parser logic.
// Reset is synchronous and active low, and returns the parser to the header.
// A stalled result holds the result register; the input register still takes
// one more byte, and bytes that give no result keep flowing through.
module server_address_list_parser #(
    parameter int HEADER_BYTES = 22
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,   // [63:0] addr_upper, [127:64] addr_lower,
                                         // [143:128] port_number
    output logic [3:0]   m_axis_tuser,   // [2:0] kind, [3] is_ipv6
    output logic         m_axis_tlast
);
    import slp_pkg::*;

    t_in_item w_in_item;
    t_in_item w_stage_item;
    logic     w_stage_valid;
    logic     w_consume;
    logic     w_res_load;
    t_result  w_core_res;
    logic     w_out_free;
    t_result  w_out_res;

    assign w_in_item.data_byte = s_axis_tdata;
    assign w_in_item.last_byte = s_axis_tlast;

    // Input register.
    slp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_item    (w_in_item),
        .i_consume (w_consume),
        .o_ready   (s_axis_tready),
        .o_valid   (w_stage_valid),
        .o_item    (w_stage_item)
    );

    // Parser logic.
    slp_core #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_stage_valid),
        .i_item       (w_stage_item),
        .i_out_free   (w_out_free),
        .o_consume    (w_consume),
        .o_res_load   (w_res_load),
        .o_res        (w_core_res)
    );

    // Result register.
    slp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_load),
        .i_res   (w_core_res),
        .i_ready (m_axis_tready),
        .o_free  (w_out_free),
        .o_valid (m_axis_tvalid),
        .o_res   (w_out_res)
    );

    // Output packing.
    assign m_axis_tdata = {w_out_res.port_number, w_out_res.addr_lower, w_out_res.addr_upper};
    assign m_axis_tuser = {w_out_res.is_ipv6, w_out_res.kind};
    assign m_axis_tlast = w_out_res.end_of_message;

endmodule

// File: hdl/slp_in_reg.sv
// Input register stage of the server address list parser.
module slp_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  slp_pkg::t_in_item i_item,
    input  logic             i_consume,
    output logic             o_ready,
    output logic             o_valid,
    output slp_pkg::t_in_item o_item
);
    import slp_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // The stage takes a new request when it is empty or its content moves on.
    assign o_ready = !r_valid || i_consume;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload holds while stalled.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: hdl/slp_core.sv
// Byte parser: phase tracking, record assembly and result decode.
module slp_core #(
    parameter int HEADER_BYTES = 22
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  slp_pkg::t_in_item i_item,
    input  logic              i_out_free,
    output logic              o_consume,
    output logic              o_res_load,
    output slp_pkg::t_result  o_res
);
    import slp_pkg::*;

    localparam int HC_W = (HEADER_BYTES < 1) ? 1 : $clog2(HEADER_BYTES + 1);
    localparam logic [HC_W-1:0] HDR_LEN = HC_W'(HEADER_BYTES);

    t_phase      r_phase, n_phase;
    logic [HC_W-1:0] r_hc, n_hc;
    logic [4:0]  r_rc, n_rc;
    logic        r_v6, n_v6;
    logic [63:0] r_upper, n_upper;
    logic [63:0] r_lower, n_lower;
    logic [7:0]  r_plow, n_plow;

    logic [HC_W-1:0] w_hc_inc;
    logic        w_hdr_done;
    logic        w_hdr_active;
    logic        w_prefix_active;
    logic        w_body_active;
    logic        w_hc_reach;
    logic        w_mark_ok;
    logic [4:0]  w_alen;
    logic        w_in_addr;
    logic        w_at_plow;
    logic [15:0] w_port;
    logic        w_res_hit;
    logic        w_fire;
    logic [7:0]  w_byte;
    logic        w_last;

    assign w_byte = i_item.data_byte;
    assign w_last = i_item.last_byte;

    // Decode of where this byte falls in the datagram.
    assign w_hdr_done      = (r_hc >= HDR_LEN);
    assign w_hdr_active    = (r_phase == PH_HEADER) && !w_hdr_done;
    assign w_prefix_active = (r_phase == PH_PREFIX) || ((r_phase == PH_HEADER) && w_hdr_done);
    assign w_body_active   = (r_phase == PH_BODY);
    assign w_hc_inc        = r_hc + HC_W'(1);
    assign w_hc_reach      = (w_hc_inc >= HDR_LEN);
    assign w_mark_ok       = (w_byte == MARK_V4) || (w_byte == MARK_V6);
    assign w_alen          = r_v6 ? V6_BYTES : V4_BYTES;
    assign w_in_addr       = (r_rc < w_alen);
    assign w_at_plow       = (r_rc == w_alen);
    assign w_port          = {w_byte, r_plow};

    // A byte is processed when its result, if any, has room to go.
    assign w_fire     = i_item_valid && (!w_res_hit || i_out_free);
    assign o_consume  = w_fire;
    assign o_res_load = w_fire && w_res_hit;

    // Next phase: the final byte always returns to the header phase.
    always_comb begin
        n_phase = r_phase;
        if (w_last) begin
            n_phase = PH_HEADER;
        end else if (w_hdr_active) begin
            n_phase = w_hc_reach ? PH_PREFIX : PH_HEADER;
        end else if (w_prefix_active) begin
            n_phase = w_mark_ok ? PH_BODY : PH_DISCARD;
        end else if (w_body_active) begin
            if (w_in_addr || w_at_plow) begin
                n_phase = PH_BODY;
            end else if (w_port == 16'd0) begin
                n_phase = PH_DISCARD;
            end else begin
                n_phase = PH_PREFIX;
            end
        end else begin
            n_phase = PH_DISCARD;
        end
    end

    // Datapath updates and the result of this byte.
    always_comb begin
        n_hc      = r_hc;
        n_rc      = r_rc;
        n_v6      = r_v6;
        n_upper   = r_upper;
        n_lower   = r_lower;
        n_plow    = r_plow;
        w_res_hit = 1'b0;
        o_res     = '0;
        o_res.kind           = KIND_RECORD;
        o_res.end_of_message = 1'b1;

        if (w_hdr_active) begin
            n_hc = w_last ? '0 : w_hc_inc;
            if (w_last) begin
                w_res_hit  = 1'b1;
                o_res.kind = w_hc_reach ? KIND_CLEAN : KIND_SHORT;
            end
        end else if (w_prefix_active) begin
            if (w_last) begin
                n_hc = '0;
            end
            if (!w_mark_ok) begin
                w_res_hit  = 1'b1;
                o_res.kind = KIND_ILLEGAL;
            end else begin
                n_v6    = (w_byte == MARK_V6);
                n_rc    = 5'd0;
                n_upper = '0;
                n_lower = '0;
                if (w_last) begin
                    w_res_hit  = 1'b1;
                    o_res.kind = KIND_TRUNC;
                end
            end
        end else if (w_body_active) begin
            if (w_last) begin
                n_hc = '0;
            end
            if (w_in_addr || w_at_plow) begin
                n_rc = r_rc + 5'd1;
                if (w_in_addr) begin
                    n_upper = {r_upper[55:0], r_lower[63:56]};
                    n_lower = {r_lower[55:0], w_byte};
                end else begin
                    n_plow = w_byte;
                end
                if (w_last) begin
                    w_res_hit  = 1'b1;
                    o_res.kind = KIND_TRUNC;
                end
            end else begin
                w_res_hit = 1'b1;
                n_rc      = 5'd0;
                if (w_port == 16'd0) begin
                    o_res.kind = KIND_ZERO_PORT;
                end else begin
                    o_res.kind           = KIND_RECORD;
                    o_res.is_ipv6        = r_v6;
                    o_res.addr_upper     = r_upper;
                    o_res.addr_lower     = r_lower;
                    o_res.port_number    = w_port;
                    o_res.end_of_message = w_last;
                end
            end
        end else begin
            // Discarded byte: only the datagram restart matters.
            if (w_last) begin
                n_hc = '0;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_hc    <= '0;
            r_rc    <= 5'd0;
            r_v6    <= 1'b0;
        end else if (w_fire) begin
            r_phase <= n_phase;
            r_hc    <= n_hc;
            r_rc    <= n_rc;
            r_v6    <= n_v6;
        end
    end

    // Record payload registers.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_upper <= n_upper;
            r_lower <= n_lower;
            r_plow  <= n_plow;
        end
    end

endmodule

// File: hdl/slp_out_reg.sv
// Result register stage of the server address list parser.
module slp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  slp_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output slp_pkg::t_result o_res
);
    import slp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Room for a new result when empty or the held one leaves now.
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
